>>> src/tof_event_frame_unwrap_filter_assert.svh
// Assertion macros shared by the event unwrap filter RTL.
`ifndef TOF_EVENT_FRAME_UNWRAP_FILTER_ASSERT_SVH
`define TOF_EVENT_FRAME_UNWRAP_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TEFU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define TEFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/tefu_pkg.sv
// Package: shared types and constants of the event unwrap filter.
package tefu_pkg;

  localparam int RST_FRAME_WIDTH = 166667;
  localparam int RST_WRAP_PERIOD = 166667;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_PERIOD  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUT      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CUT     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_CORR    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SKIP   = 4'd7;

  localparam int PULSE_BITS = 63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CHECK,
    ST_GAP,
    ST_FOLD,
    ST_EMIT
  } tefu_state_t;

endpackage

>>> src/tefu_front.sv
// Front part: accept events, add the frame offset, hold them in a two-word queue.
module tefu_front
  import tefu_pkg::*;
#(
  parameter int TIME_BITS        = 26,
  parameter int FACTOR_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [TIME_BITS-1:0]          event_time,
  input  logic [PULSE_BITS-1:0]         pulse_time,
  input  logic [FACTOR_FRAC_BITS+1:0]   path_factor,
  input  logic [TIME_BITS-1:0]          time_offset,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic [TIME_BITS:0]            q_time,
  output logic [PULSE_BITS-1:0]         q_pulse,
  output logic [FACTOR_FRAC_BITS+1:0]   q_factor
);

  logic [TIME_BITS:0]          slot_time   [2];
  logic [PULSE_BITS-1:0]       slot_pulse  [2];
  logic [FACTOR_FRAC_BITS+1:0] slot_factor [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;
  logic                        push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_time   = slot_time[rd_ptr];
  assign q_pulse  = slot_pulse[rd_ptr];
  assign q_factor = slot_factor[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_time[wr_ptr]   <= {1'b0, event_time} + {1'b0, time_offset};
      slot_pulse[wr_ptr]  <= pulse_time;
      slot_factor[wr_ptr] <= path_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

>>> src/tefu_div.sv
// Shared restoring divider: one quotient bit per cycle, gives quotient and remainder.
module tefu_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] dvd;
  logic [DEN_W-1:0] rmd;
  logic [DEN_W-1:0] dvr;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rmd, dvd[NUM_W-1]};
  assign ge    = (trial >= {1'b0, dvr});
  assign diff  = trial - {1'b0, dvr};
  assign quot  = dvd;
  assign rem   = rmd;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rmd <= '0;
      dvr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[NUM_W-2:0], ge};
      rmd <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/tefu_back.sv
// Back part: sequence scaling, unwrap and fold on the divider, cut and emit the result.
module tefu_back
  import tefu_pkg::*;
#(
  parameter int TIME_BITS        = 26,
  parameter int FACTOR_FRAC_BITS = 16,
  parameter int NUM_W            = 43,
  parameter int DEN_W            = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  logic [TIME_BITS:0]          q_time,
  input  logic [PULSE_BITS-1:0]       q_pulse,
  input  logic [FACTOR_FRAC_BITS+1:0] q_factor,
  input  logic [TIME_BITS-1:0]        threshold,
  input  logic [TIME_BITS-1:0]        frame_width,
  input  logic [TIME_BITS-1:0]        wrap_period,
  input  logic [TIME_BITS-1:0]        low_cut,
  input  logic [TIME_BITS-1:0]        high_cut,
  input  logic                        path_correction_on,
  input  logic                        frame_skip_on,
  output logic                        div_start,
  output logic [NUM_W-1:0]            div_dividend,
  output logic [DEN_W-1:0]            div_divisor,
  input  logic                        div_done,
  input  logic [NUM_W-1:0]            div_quot,
  input  logic [DEN_W-1:0]            div_rem,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [TIME_BITS-1:0]        out_time,
  output logic [PULSE_BITS-1:0]       out_pulse
);

  localparam int WT = TIME_BITS + 2;
  localparam logic [WT-1:0] WIDE_MAX = '1;

  tefu_state_t state, state_next;

  logic [WT-1:0]         t_w;
  logic [PULSE_BITS-1:0] pulse;
  logic                  keep;

  logic                  scale_go;
  logic [TIME_BITS-1:0]  step_eff;
  logic [TIME_BITS-1:0]  width_eff;
  logic [WT-1:0]         thr_ext;
  logic                  below;
  logic [WT-1:0]         rel;
  logic [WT-1:0]         gap;
  logic [DEN_W-1:0]      back_off;
  logic [DEN_W:0]        x_hi;
  logic                  cut;
  logic                  skip;
  logic [WT:0]           t_fin;
  logic                  out_free;

  assign scale_go  = path_correction_on && (q_factor != '0);
  assign step_eff  = (wrap_period == '0) ? TIME_BITS'(1) : wrap_period;
  assign width_eff = (frame_width == '0) ? TIME_BITS'(1) : frame_width;
  assign thr_ext   = WT'(threshold);
  assign below     = (t_w < thr_ext);
  assign rel       = t_w - thr_ext;
  assign gap       = thr_ext - t_w;
  // Distance above threshold after whole unwrap steps
  assign back_off  = (div_rem == '0) ? '0 : (DEN_W'(step_eff) - div_rem);
  assign x_hi      = {1'b0, div_rem} + (DEN_W+1)'(high_cut);
  assign cut       = (div_rem < DEN_W'(low_cut)) || (x_hi > (DEN_W+1)'(width_eff));
  assign skip      = frame_skip_on && (rel > WT'(width_eff));
  assign t_fin     = {1'b0, t_w} + (skip ? (WT+1)'(width_eff) : '0);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (q_valid) state_next = scale_go ? ST_SCALE : ST_CHECK;
      ST_SCALE: if (div_done) state_next = ST_CHECK;
      ST_CHECK: state_next = below ? ST_GAP : ST_FOLD;
      ST_GAP:   if (div_done) state_next = ST_CHECK;
      ST_FOLD:  if (div_done) state_next = ST_EMIT;
      ST_EMIT:  if (!keep || out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid && scale_go) begin
          div_start    = 1'b1;
          div_dividend = NUM_W'({q_time, {FACTOR_FRAC_BITS{1'b0}}});
          div_divisor  = DEN_W'(q_factor);
        end
      end
      ST_CHECK: begin
        div_start = 1'b1;
        if (below) begin
          div_dividend = NUM_W'(gap);
          div_divisor  = DEN_W'(step_eff);
        end else begin
          div_dividend = NUM_W'(rel);
          div_divisor  = DEN_W'(width_eff);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      pulse <= q_pulse;
      if (!path_correction_on) t_w <= WT'(q_time);
      else if (q_factor == '0) t_w <= WIDE_MAX;
    end
    if (state == ST_SCALE && div_done) begin
      t_w <= (div_quot > NUM_W'(WIDE_MAX)) ? WIDE_MAX : div_quot[WT-1:0];
    end
    if (state == ST_GAP && div_done) begin
      t_w <= thr_ext + WT'(back_off);
    end
    if (state == ST_FOLD && div_done) begin
      keep <= !cut;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && keep && out_free) begin
      out_time  <= (t_fin[WT:TIME_BITS] != '0) ? '1 : t_fin[TIME_BITS-1:0];
      out_pulse <= pulse;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && keep && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/tof_event_frame_unwrap_filter.sv
// Top level of the time-of-flight frame unwrap and edge-cut event filter.
//
// Usage: events enter on the s_axis word channel (time of flight, pulse stamp,
// flight-path factor); kept events leave on m_axis with the corrected time and
// the unchanged pulse stamp. Dropped events produce no output word.
// Registers are written on the cfg channel (always ready); the user must write
// them only while the block is idle, and the block itself does not enforce this.
// The front takes a word in any cycle while its two-word queue has room. The back
// runs each event over one shared bit-serial divider: one division for the path
// scaling (when on and the factor is nonzero), one for the unwrap step count
// (when below threshold) and one for the frame fold. The back works on one event
// at a time and pops the next word only when it is idle again; meanwhile the
// front queue goes on taking words.
// Reset clears the queue, the sequencer and the output valid, and loads the
// register reset values. When m_axis stalls the finished word holds in the output
// register; the back holds its next result, then the queue fills and s_axis
// tready falls.
module tof_event_frame_unwrap_filter
  import tefu_pkg::*;
#(
  parameter int TIME_BITS        = 26,
  parameter int FACTOR_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // event_time, pulse_time, path_factor from bit 0 up, zero padded to bytes
  input  logic [((TIME_BITS+PULSE_BITS+FACTOR_FRAC_BITS+2+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // corrected_time, pulse_stamp from bit 0 up, zero padded to bytes
  output logic [((TIME_BITS+PULSE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TIME_BITS-1:0]   cfg_data
);

  localparam int OUT_W = ((TIME_BITS + PULSE_BITS + 7) / 8) * 8;
  localparam int NUM_W = TIME_BITS + FACTOR_FRAC_BITS + 1;
  localparam int DEN_W = (TIME_BITS > FACTOR_FRAC_BITS + 2) ? TIME_BITS
                                                            : FACTOR_FRAC_BITS + 2;
  localparam int FAC_LO = TIME_BITS + PULSE_BITS;

  // Configuration registers
  logic [TIME_BITS-1:0] time_offset;
  logic [TIME_BITS-1:0] threshold;
  logic [TIME_BITS-1:0] frame_width;
  logic [TIME_BITS-1:0] wrap_period;
  logic [TIME_BITS-1:0] low_cut;
  logic [TIME_BITS-1:0] high_cut;
  logic                 path_correction_on;
  logic                 frame_skip_on;

  logic                        q_valid;
  logic                        q_pop;
  logic [TIME_BITS:0]          q_time;
  logic [PULSE_BITS-1:0]       q_pulse;
  logic [FACTOR_FRAC_BITS+1:0] q_factor;

  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [NUM_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic [NUM_W-1:0] div_quot;
  logic [DEN_W-1:0] div_rem;

  logic [TIME_BITS-1:0]  out_time;
  logic [PULSE_BITS-1:0] out_pulse;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_offset        <= '0;
      threshold          <= '0;
      frame_width        <= TIME_BITS'(RST_FRAME_WIDTH);
      wrap_period        <= TIME_BITS'(RST_WRAP_PERIOD);
      low_cut            <= '0;
      high_cut           <= '0;
      path_correction_on <= 1'b0;
      frame_skip_on      <= 1'b0;
    end else if (cfg_valid) begin
      // Ignore indexes beyond the register list
      case (cfg_index)
        CFG_TIME_OFFSET:  time_offset        <= cfg_data;
        CFG_THRESHOLD:    threshold          <= cfg_data;
        CFG_FRAME_WIDTH:  frame_width        <= cfg_data;
        CFG_WRAP_PERIOD:  wrap_period        <= cfg_data;
        CFG_LOW_CUT:      low_cut            <= cfg_data;
        CFG_HIGH_CUT:     high_cut           <= cfg_data;
        CFG_PATH_CORR:    path_correction_on <= cfg_data[0];
        CFG_FRAME_SKIP:   frame_skip_on      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tefu_front #(
    .TIME_BITS        (TIME_BITS),
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .event_time   (s_axis_tdata[TIME_BITS-1:0]),
    .pulse_time   (s_axis_tdata[FAC_LO-1:TIME_BITS]),
    .path_factor  (s_axis_tdata[FAC_LO+FACTOR_FRAC_BITS+1:FAC_LO]),
    .time_offset  (time_offset),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_time       (q_time),
    .q_pulse      (q_pulse),
    .q_factor     (q_factor)
  );

  tefu_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  tefu_back #(
    .TIME_BITS        (TIME_BITS),
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
    .NUM_W            (NUM_W),
    .DEN_W            (DEN_W)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_time             (q_time),
    .q_pulse            (q_pulse),
    .q_factor           (q_factor),
    .threshold          (threshold),
    .frame_width        (frame_width),
    .wrap_period        (wrap_period),
    .low_cut            (low_cut),
    .high_cut           (high_cut),
    .path_correction_on (path_correction_on),
    .frame_skip_on      (frame_skip_on),
    .div_start          (div_start),
    .div_dividend       (div_dividend),
    .div_divisor        (div_divisor),
    .div_done           (div_done),
    .div_quot           (div_quot),
    .div_rem            (div_rem),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_time           (out_time),
    .out_pulse          (out_pulse)
  );

  assign m_axis_tdata = OUT_W'({out_pulse, out_time});

`include "tof_event_frame_unwrap_filter_assert.svh"

  `TEFU_ASSERT_IMPL(a_pop_has_word, clk, rst, q_pop, q_valid)
  `TEFU_ASSERT_IMPL(a_start_when_free, clk, rst, div_start, !div_busy)
  `TEFU_ASSERT_NEXT(a_start_runs, clk, rst, div_start, div_busy)

endmodule
